/* hw/rtl/cpid_pkg.sv */
`default_nettype none
package cpid_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SUM_WIDTH = 48;
  localparam int DATA_W    = 32;
  localparam int REF_W     = 17;
  localparam int CFG_IDX_W = 3;

  // Tilt limit of 0.523 rad in fixed point
  localparam longint LIM_L = (longint'(523) << FRAC_BITS) / 1000;
  localparam logic signed [DATA_W-1:0] ANGLE_LIM = DATA_W'(LIM_L);

  localparam logic [CFG_IDX_W-1:0] REG_KP        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KI_DT     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KD_INV_DT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TILT_KP   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_TILT_KD   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y  = CFG_IDX_W'(6);

  localparam logic OP_OUTER = 1'b0;
  localparam logic OP_INNER = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki_dt;
    logic signed [DATA_W-1:0] kd_inv_dt;
    logic signed [DATA_W-1:0] tilt_kp;
    logic signed [DATA_W-1:0] tilt_kd;
    logic signed [DATA_W-1:0] target_x;
    logic signed [DATA_W-1:0] target_y;
  } cfg_t;

  // Stage-one results, named by the reference axis they drive
  typedef struct packed {
    logic                        op;
    logic signed [DATA_W-1:0]    ce_x;
    logic signed [DATA_W-1:0]    de_x;
    logic signed [SUM_WIDTH-1:0] sum_x;
    logic signed [DATA_W-1:0]    ce_y;
    logic signed [DATA_W-1:0]    de_y;
    logic signed [SUM_WIDTH-1:0] sum_y;
    logic signed [DATA_W-1:0]    tilt_x;
    logic signed [DATA_W-1:0]    tilt_y;
    logic signed [DATA_W-1:0]    rate_x;
    logic signed [DATA_W-1:0]    rate_y;
  } mid_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] vmax;
    logic signed [63:0] vmin;
    vmax = 64'sh0000_0000_7FFF_FFFF;
    vmin = -64'sh0000_0000_8000_0000;
    if (v > vmax) return vmax[DATA_W-1:0];
    if (v < vmin) return vmin[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sub_sat(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    return sat32(64'(a) - 64'(b));
  endfunction

  function automatic logic signed [SUM_WIDTH-1:0] sum_add(
      input logic signed [SUM_WIDTH-1:0] s, input logic signed [DATA_W-1:0] e);
    logic signed [SUM_WIDTH:0] w;
    w = (SUM_WIDTH+1)'(s) + (SUM_WIDTH+1)'(e);
    if (w[SUM_WIDTH] != w[SUM_WIDTH-1]) begin
      return w[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end
    return w[SUM_WIDTH-1:0];
  endfunction

  // Q product: exact product shifted right, truncated toward zero, saturated
  function automatic logic signed [DATA_W-1:0] mulq(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [63:0] b);
    logic        neg;
    logic [31:0] ua;
    logic [63:0] ub;
    logic [63:0] plo;
    logic [63:0] phi;
    logic [95:0] prod;
    logic [95:0] r;
    neg  = a[DATA_W-1] ^ b[63];
    ua   = a[DATA_W-1] ? 32'(-a) : 32'(a);
    ub   = b[63] ? 64'(-b) : 64'(b);
    plo  = {32'b0, ua} * {32'b0, ub[31:0]};
    phi  = {32'b0, ua} * {32'b0, ub[63:32]};
    prod = 96'(plo) + (96'(phi) << 32);
    r    = prod >> FRAC_BITS;
    if (neg) begin
      if (r >= 96'h8000_0000) return 32'sh8000_0000;
      return 32'(-r);
    end
    if (r > 96'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/cpid_cfg.sv */
`default_nettype none
module cpid_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [cpid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cpid_pkg::DATA_W-1:0]     cfg_data,
  output cpid_pkg::cfg_t                       cfg
);
  import cpid_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP:        cfg.kp        <= cfg_data;
        REG_KI_DT:     cfg.ki_dt     <= cfg_data;
        REG_KD_INV_DT: cfg.kd_inv_dt <= cfg_data;
        REG_TILT_KP:   cfg.tilt_kp   <= cfg_data;
        REG_TILT_KD:   cfg.tilt_kd   <= cfg_data;
        REG_TARGET_X:  cfg.target_x  <= cfg_data;
        REG_TARGET_Y:  cfg.target_y  <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cpid_front.sv */
`default_nettype none
module cpid_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cpid_pkg::cfg_t                    cfg,
  input  wire logic                              load,
  input  wire logic                              opcode,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] pos_x,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] pos_y,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] prev_pos_x,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] prev_pos_y,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] tilt_x,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] tilt_y,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] tilt_rate_x,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] tilt_rate_y,
  output cpid_pkg::mid_t                         mid
);
  import cpid_pkg::*;

  logic signed [SUM_WIDTH-1:0] err_sum_x;
  logic signed [SUM_WIDTH-1:0] err_sum_y;
  logic signed [DATA_W-1:0]    pe_x;
  logic signed [DATA_W-1:0]    pe_y;
  mid_t                        mid_next;

  // Crossed axes: y position error drives the x reference, and vice versa
  always_comb begin
    mid_next        = '0;
    mid_next.op     = opcode;
    mid_next.ce_x   = sub_sat(cfg.target_y, pos_y);
    pe_x            = sub_sat(cfg.target_y, prev_pos_y);
    mid_next.de_x   = sub_sat(mid_next.ce_x, pe_x);
    mid_next.sum_x  = sum_add(err_sum_y, mid_next.ce_x);
    mid_next.ce_y   = sub_sat(cfg.target_x, pos_x);
    pe_y            = sub_sat(cfg.target_x, prev_pos_x);
    mid_next.de_y   = sub_sat(mid_next.ce_y, pe_y);
    mid_next.sum_y  = sum_add(err_sum_x, mid_next.ce_y);
    mid_next.tilt_x = tilt_x;
    mid_next.tilt_y = tilt_y;
    mid_next.rate_x = tilt_rate_x;
    mid_next.rate_y = tilt_rate_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_sum_x <= '0;
      err_sum_y <= '0;
    end else if (load && opcode == OP_OUTER) begin
      err_sum_y <= mid_next.sum_x;
      err_sum_x <= mid_next.sum_y;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mid <= mid_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cpid_law.sv */
`default_nettype none
module cpid_law (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire cpid_pkg::cfg_t                     cfg,
  input  wire cpid_pkg::mid_t                     mid,
  input  wire logic                               move,
  output logic signed [cpid_pkg::REF_W-1:0]       ref_angle_x,
  output logic signed [cpid_pkg::REF_W-1:0]       ref_angle_y,
  output logic signed [cpid_pkg::DATA_W-1:0]      torque_out_x,
  output logic signed [cpid_pkg::DATA_W-1:0]      torque_out_y
);
  import cpid_pkg::*;

  localparam logic signed [DATA_W+1:0] LIM_W = (DATA_W+2)'(ANGLE_LIM);

  logic signed [DATA_W-1:0] ref_tilt_x;
  logic signed [DATA_W-1:0] ref_tilt_y;
  logic signed [DATA_W-1:0] ref_tilt_x_next;
  logic signed [DATA_W-1:0] ref_tilt_y_next;
  logic signed [DATA_W+1:0] t_x;
  logic signed [DATA_W+1:0] t_y;
  logic signed [DATA_W-1:0] e_x;
  logic signed [DATA_W-1:0] e_y;
  logic signed [DATA_W-1:0] d_x;
  logic signed [DATA_W-1:0] d_y;
  logic signed [DATA_W-1:0] tq_x;
  logic signed [DATA_W-1:0] tq_y;

  function automatic logic signed [DATA_W-1:0] clamp_lim(input logic signed [DATA_W+1:0] t);
    if (t > LIM_W) return ANGLE_LIM;
    if (t < -LIM_W) return -ANGLE_LIM;
    return t[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] rate_term(input logic signed [DATA_W-1:0] e,
                                                         input logic signed [DATA_W-1:0] r);
    if (e > 0) return sat32(-64'(r));
    if (e < 0) return r;
    return '0;
  endfunction

  // Outer law: three saturated products added exactly, then clamped
  always_comb begin
    t_x = (DATA_W+2)'(mulq(cfg.kp, 64'(mid.ce_x)))
        + (DATA_W+2)'(mulq(cfg.kd_inv_dt, 64'(mid.de_x)))
        + (DATA_W+2)'(mulq(cfg.ki_dt, 64'($signed(mid.sum_x))));
    t_y = (DATA_W+2)'(mulq(cfg.kp, 64'(mid.ce_y)))
        + (DATA_W+2)'(mulq(cfg.kd_inv_dt, 64'(mid.de_y)))
        + (DATA_W+2)'(mulq(cfg.ki_dt, 64'($signed(mid.sum_y))));
  end

  // Inner law: PD with a sign-steered rate term
  always_comb begin
    e_x  = sub_sat(ref_tilt_x, mid.tilt_x);
    e_y  = sub_sat(ref_tilt_y, mid.tilt_y);
    d_x  = rate_term(e_x, mid.rate_x);
    d_y  = rate_term(e_y, mid.rate_y);
    tq_x = sat32(64'(mulq(cfg.tilt_kp, 64'(e_x))) + 64'(mulq(cfg.tilt_kd, 64'(d_x))));
    tq_y = sat32(64'(mulq(cfg.tilt_kp, 64'(e_y))) + 64'(mulq(cfg.tilt_kd, 64'(d_y))));
  end

  always_comb begin
    if (mid.op == OP_OUTER) begin
      ref_tilt_x_next = clamp_lim(t_x);
      ref_tilt_y_next = clamp_lim(t_y);
    end else begin
      ref_tilt_x_next = ref_tilt_x;
      ref_tilt_y_next = ref_tilt_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_tilt_x <= '0;
      ref_tilt_y <= '0;
    end else if (move) begin
      ref_tilt_x <= ref_tilt_x_next;
      ref_tilt_y <= ref_tilt_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      ref_angle_x  <= ref_tilt_x_next[REF_W-1:0];
      ref_angle_y  <= ref_tilt_y_next[REF_W-1:0];
      torque_out_x <= (mid.op == OP_INNER) ? tq_x : '0;
      torque_out_y <= (mid.op == OP_INNER) ? tq_y : '0;
    end
  end

  a_ref_hold: assert property (@(posedge clk) disable iff (rst)
    !(move && mid.op == OP_OUTER) |=> $stable(ref_tilt_x) && $stable(ref_tilt_y))
    else $error("reference tilt changed without an outer request");

  a_ref_bound: assert property (@(posedge clk) disable iff (rst)
    ref_tilt_x <= ANGLE_LIM && ref_tilt_x >= -ANGLE_LIM &&
    ref_tilt_y <= ANGLE_LIM && ref_tilt_y >= -ANGLE_LIM)
    else $error("reference tilt outside the clamp");

  a_outer_zero_torque: assert property (@(posedge clk) disable iff (rst)
    move && mid.op == OP_OUTER |=> torque_out_x == '0 && torque_out_y == '0)
    else $error("outer result carries torque");

  a_angle_tracks: assert property (@(posedge clk) disable iff (rst)
    move |=> ref_angle_x == ref_tilt_x[REF_W-1:0] && ref_angle_y == ref_tilt_y[REF_W-1:0])
    else $error("result angle differs from stored reference");

endmodule
`default_nettype wire

/* hw/rtl/cascaded_two_axis_pid.sv */
`default_nettype none
// Two-axis cascaded ball-on-table controller in signed Q16.16. Each request
// carries an opcode: an outer request (opcode 0) takes current and previous
// ball positions and updates the stored reference tilts through a crossed PID
// (y error drives the x tilt), clamped to +/-0.523 rad; an inner request
// (opcode 1) takes table angles and rates and returns PD torques against the
// stored references. Every request yields exactly one result holding both
// reference angles and both torques (torques are zero for outer requests).
// The block takes one request per clock. Stage one forms errors and updates
// the error sums as the request is accepted into the stage-one register; the
// result register is loaded from it with the gain products, clamp and torque
// saturation once the result register is free. Back-pressure on the result
// side stalls both stages; while a result waits a request is still taken
// only when stage one is empty. Write gains and targets only while no
// request is in flight; valid flags, gains, error sums and reference tilts
// clear to zero on reset; the stage-one and result data registers do not.
module cascaded_two_axis_pid (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [cpid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cpid_pkg::DATA_W-1:0]        cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               opcode,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] pos_x,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] pos_y,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] prev_pos_x,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] prev_pos_y,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] tilt_x,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] tilt_y,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] tilt_rate_x,
  input  wire logic signed [cpid_pkg::DATA_W-1:0] tilt_rate_y,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [cpid_pkg::REF_W-1:0]       ref_angle_x,
  output logic signed [cpid_pkg::REF_W-1:0]       ref_angle_y,
  output logic signed [cpid_pkg::DATA_W-1:0]      torque_out_x,
  output logic signed [cpid_pkg::DATA_W-1:0]      torque_out_y
);
  import cpid_pkg::*;

  cfg_t cfg;
  mid_t mid;
  logic mid_valid;
  logic out_free;
  logic move;
  logic accept;

  // Result register frees when empty or taken this cycle
  assign out_free = !out_valid || out_ready;
  // Advance the stage-one request into the result register
  assign move     = mid_valid && out_free;
  assign in_ready = !mid_valid || move;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        mid_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= mid_valid;
      end
    end
  end

  cpid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage one: errors, differences and error sums; holds the sums
  cpid_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .load        (accept),
    .opcode      (opcode),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .prev_pos_x  (prev_pos_x),
    .prev_pos_y  (prev_pos_y),
    .tilt_x      (tilt_x),
    .tilt_y      (tilt_y),
    .tilt_rate_x (tilt_rate_x),
    .tilt_rate_y (tilt_rate_y),
    .mid         (mid)
  );

  // Stage two: gain products, clamp, reference tilts and result register
  cpid_law u_law (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .mid          (mid),
    .move         (move),
    .ref_angle_x  (ref_angle_x),
    .ref_angle_y  (ref_angle_y),
    .torque_out_x (torque_out_x),
    .torque_out_y (torque_out_y)
  );

endmodule
`default_nettype wire

/* dv/cascaded_two_axis_pid_tb.sv */
module cascaded_two_axis_pid_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpid_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 1760;
  localparam int REPORT_LINES  = 20;

  // Unmapped register index: writes to it must leave every gain and target alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(7);

  localparam logic signed [DATA_W-1:0] W_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] W_MAX = 32'sh7FFF_FFFF;

  localparam longint I32_MAX   = 64'sd2147483647;
  localparam longint I32_MIN   = -64'sd2147483648;
  localparam longint SUM_MAX   = (64'sd1 <<< (SUM_WIDTH - 1)) - 64'sd1;
  localparam longint SUM_MIN   = -SUM_MAX - 64'sd1;
  localparam longint ANGLE_MAX = longint'(ANGLE_LIM);

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] prev_pos_x;
    logic signed [DATA_W-1:0] prev_pos_y;
    logic signed [DATA_W-1:0] tilt_x;
    logic signed [DATA_W-1:0] tilt_y;
    logic signed [DATA_W-1:0] tilt_rate_x;
    logic signed [DATA_W-1:0] tilt_rate_y;
  } pid_req_t;

  typedef struct packed {
    logic signed [REF_W-1:0]  ref_angle_x;
    logic signed [REF_W-1:0]  ref_angle_y;
    logic signed [DATA_W-1:0] torque_out_x;
    logic signed [DATA_W-1:0] torque_out_y;
  } pid_rsp_t;

  // Clock, reset and every block input start at known values
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0]     cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  out_ready = 1'b0;
  pid_req_t              drive_req = '0;

  logic                     in_ready;
  logic                     out_valid;
  logic signed [REF_W-1:0]  ref_angle_x;
  logic signed [REF_W-1:0]  ref_angle_y;
  logic signed [DATA_W-1:0] torque_out_x;
  logic signed [DATA_W-1:0] torque_out_y;

  // Predictor state: our own copy of the gains, stored reference tilts and error sums
  cfg_t   shadow_cfg  = '0;
  longint tilt_ref_x  = 0;
  longint tilt_ref_y  = 0;
  longint ball_sum_x  = 0;
  longint ball_sum_y  = 0;

  pid_rsp_t pending_results[$];

  int idle_pct        = 0;
  int stall_pct       = 0;
  int mismatches      = 0;
  int results_checked = 0;
  int outer_count     = 0;
  int inner_count     = 0;
  int reg_writes      = 0;
  int cycle_count     = 0;

  cascaded_two_axis_pid u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (drive_req.opcode),
    .pos_x        (drive_req.pos_x),
    .pos_y        (drive_req.pos_y),
    .prev_pos_x   (drive_req.prev_pos_x),
    .prev_pos_y   (drive_req.prev_pos_y),
    .tilt_x       (drive_req.tilt_x),
    .tilt_y       (drive_req.tilt_y),
    .tilt_rate_x  (drive_req.tilt_rate_x),
    .tilt_rate_y  (drive_req.tilt_rate_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ref_angle_x  (ref_angle_x),
    .ref_angle_y  (ref_angle_y),
    .torque_out_x (torque_out_x),
    .torque_out_y (torque_out_y)
  );

  always #10 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Hard stop in case the block hangs
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timed out after %0d cycles with %0d results outstanding", cycle_count,
             pending_results.size());
    $display("cascaded_two_axis_pid: mismatch");
    $finish;
  end

  // Result side back-pressure: stall a random share of cycles per phase
  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the controller
  // ---------------------------------------------------------------------------

  function automatic longint as_long(input logic signed [DATA_W-1:0] v);
    return v;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  function automatic longint add_to_sum(input longint s, input longint e);
    longint w;
    w = s + e;
    if (w > SUM_MAX) return SUM_MAX;
    if (w < SUM_MIN) return SUM_MIN;
    return w;
  endfunction

  // Exact magnitude product, shift out the fraction (truncates toward zero),
  // then saturate to 32 bits. Error sums reach 48 bits, so go 128 wide.
  function automatic longint scale_q(input longint a, input longint b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = ({64'd0, ma} * {64'd0, mb}) >> FRAC_BITS;
    if ((a < 0) != (b < 0)) begin
      if (p >= 128'h8000_0000) return I32_MIN;
      return -longint'(p[63:0]);
    end
    if (p > 128'h7FFF_FFFF) return I32_MAX;
    return longint'(p[63:0]);
  endfunction

  // Outer PID for one reference axis; the error sum has already been advanced
  function automatic longint outer_law(input longint target, input longint cur,
                                       input longint prev, input longint err_sum);
    longint ce;
    longint de;
    longint t;
    ce = clip32(target - cur);
    de = clip32(ce - clip32(target - prev));
    t  = scale_q(as_long(shadow_cfg.kp), ce) + scale_q(as_long(shadow_cfg.kd_inv_dt), de)
       + scale_q(as_long(shadow_cfg.ki_dt), err_sum);
    if (t > ANGLE_MAX) t = ANGLE_MAX;
    if (t < -ANGLE_MAX) t = -ANGLE_MAX;
    return t;
  endfunction

  // Inner PD: derivative is minus sign(error) times rate, zero on zero error
  function automatic longint inner_law(input longint ref_tilt, input longint tilt,
                                       input longint rate);
    longint e;
    longint d;
    e = clip32(ref_tilt - tilt);
    d = 0;
    if (e > 0) d = clip32(-rate);
    else if (e < 0) d = rate;
    return clip32(scale_q(as_long(shadow_cfg.tilt_kp), e)
                + scale_q(as_long(shadow_cfg.tilt_kd), d));
  endfunction

  // Advance the controller state by one request and return what the block must show
  function automatic pid_rsp_t predict_result(input pid_req_t req);
    pid_rsp_t rsp;
    longint   tq_x;
    longint   tq_y;
    longint   next_x;
    longint   next_y;
    tq_x = 0;
    tq_y = 0;
    if (req.opcode == OP_OUTER) begin
      // Crossed axes: y ball error steers the x tilt and the other way round
      ball_sum_y = add_to_sum(ball_sum_y,
                              clip32(as_long(shadow_cfg.target_y) - as_long(req.pos_y)));
      ball_sum_x = add_to_sum(ball_sum_x,
                              clip32(as_long(shadow_cfg.target_x) - as_long(req.pos_x)));
      next_x = outer_law(as_long(shadow_cfg.target_y), as_long(req.pos_y),
                         as_long(req.prev_pos_y), ball_sum_y);
      next_y = outer_law(as_long(shadow_cfg.target_x), as_long(req.pos_x),
                         as_long(req.prev_pos_x), ball_sum_x);
      tilt_ref_x = next_x;
      tilt_ref_y = next_y;
    end else begin
      tq_x = inner_law(tilt_ref_x, as_long(req.tilt_x), as_long(req.tilt_rate_x));
      tq_y = inner_law(tilt_ref_y, as_long(req.tilt_y), as_long(req.tilt_rate_y));
    end
    rsp.ref_angle_x  = REF_W'(tilt_ref_x);
    rsp.ref_angle_y  = REF_W'(tilt_ref_y);
    rsp.torque_out_x = DATA_W'(tq_x);
    rsp.torque_out_y = DATA_W'(tq_y);
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LINES) $display("%s", msg);
  endtask

  // Compare every accepted result against the oldest prediction
  always @(posedge clk) begin : check_results
    pid_rsp_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                  results_checked));
      end else begin
        want = pending_results.pop_front();
        if (ref_angle_x !== want.ref_angle_x)
          report_mismatch($sformatf("result %0d: ref_angle_x %0d, expected %0d",
                                    results_checked, ref_angle_x, want.ref_angle_x));
        if (ref_angle_y !== want.ref_angle_y)
          report_mismatch($sformatf("result %0d: ref_angle_y %0d, expected %0d",
                                    results_checked, ref_angle_y, want.ref_angle_y));
        if (torque_out_x !== want.torque_out_x)
          report_mismatch($sformatf("result %0d: torque_out_x %0d, expected %0d",
                                    results_checked, torque_out_x, want.torque_out_x));
        if (torque_out_y !== want.torque_out_y)
          report_mismatch($sformatf("result %0d: torque_out_y %0d, expected %0d",
                                    results_checked, torque_out_y, want.torque_out_y));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mix of extremes, values near zero and full-range words
  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(9))
      0: return W_MIN;
      1: return W_MAX;
      2: return '0;
      3: return -32'sd1;
      4, 5, 6: return DATA_W'(int'($urandom_range(0, 131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  // Gains are mostly within +/-4.0 so the outputs are not always clamped
  function automatic logic signed [DATA_W-1:0] random_gain();
    if ($urandom_range(4) == 0) return random_word();
    return DATA_W'(int'($urandom_range(0, 524288)) - 262144);
  endfunction

  function automatic longint random_step();
    int span;
    case ($urandom_range(2))
      0: span = 32'h100;
      1: span = 32'h4000;
      default: span = 32'h10_0000;
    endcase
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.kp        = random_gain();
    c.ki_dt     = random_gain();
    c.kd_inv_dt = random_gain();
    c.tilt_kp   = random_gain();
    c.tilt_kd   = random_gain();
    c.target_x  = random_word();
    c.target_y  = random_word();
    return c;
  endfunction

  // Every field random; callers overwrite the fields that matter
  function automatic pid_req_t random_request();
    pid_req_t req;
    req.opcode      = $urandom_range(1) ? OP_INNER : OP_OUTER;
    req.pos_x       = random_word();
    req.pos_y       = random_word();
    req.prev_pos_x  = random_word();
    req.prev_pos_y  = random_word();
    req.tilt_x      = random_word();
    req.tilt_y      = random_word();
    req.tilt_rate_x = random_word();
    req.tilt_rate_y = random_word();
    return req;
  endfunction

  function automatic pid_req_t make_outer(input logic signed [DATA_W-1:0] px,
                                          input logic signed [DATA_W-1:0] py,
                                          input logic signed [DATA_W-1:0] ppx,
                                          input logic signed [DATA_W-1:0] ppy);
    pid_req_t req;
    req            = random_request();
    req.opcode     = OP_OUTER;
    req.pos_x      = px;
    req.pos_y      = py;
    req.prev_pos_x = ppx;
    req.prev_pos_y = ppy;
    return req;
  endfunction

  function automatic pid_req_t make_inner(input logic signed [DATA_W-1:0] tx,
                                          input logic signed [DATA_W-1:0] ty,
                                          input logic signed [DATA_W-1:0] rx,
                                          input logic signed [DATA_W-1:0] ry);
    pid_req_t req;
    req             = random_request();
    req.opcode      = OP_INNER;
    req.tilt_x      = tx;
    req.tilt_y      = ty;
    req.tilt_rate_x = rx;
    req.tilt_rate_y = ry;
    return req;
  endfunction

  // Offer one request; hold valid and payload until it is taken, then predict
  task automatic send_request(input pid_req_t req);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    drive_req <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_result(req));
    if (req.opcode == OP_OUTER) outer_count++;
    else inner_count++;
  endtask

  // Drop valid and hold until every outstanding result has been checked
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_KP:        shadow_cfg.kp        = data;
      REG_KI_DT:     shadow_cfg.ki_dt     = data;
      REG_KD_INV_DT: shadow_cfg.kd_inv_dt = data;
      REG_TILT_KP:   shadow_cfg.tilt_kp   = data;
      REG_TILT_KD:   shadow_cfg.tilt_kd   = data;
      REG_TARGET_X:  shadow_cfg.target_x  = data;
      REG_TARGET_Y:  shadow_cfg.target_y  = data;
      default: ;  // unmapped index, block ignores it
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    wait_idle();
    write_reg(REG_KP, c.kp);
    write_reg(REG_KI_DT, c.ki_dt);
    write_reg(REG_KD_INV_DT, c.kd_inv_dt);
    write_reg(REG_TILT_KP, c.tilt_kp);
    write_reg(REG_TILT_KD, c.tilt_kd);
    write_reg(REG_TARGET_X, c.target_x);
    write_reg(REG_TARGET_Y, c.target_y);
    cfg_we <= 1'b0;
  endtask

  // Ball trajectory pulled toward the target, alternating with table poses
  // near the stored reference; some history breaks and pure noise mixed in
  task automatic run_traffic(input int count);
    pid_req_t req;
    longint   ball_x;
    longint   ball_y;
    longint   off_x;
    longint   off_y;
    int       kind;
    ball_x = clip32(as_long(shadow_cfg.target_x) + random_step());
    ball_y = clip32(as_long(shadow_cfg.target_y) + random_step());
    repeat (count) begin
      kind = $urandom_range(99);
      req  = random_request();
      if (kind < 85) begin
        if ($urandom_range(1) == 0) begin
          req.opcode     = OP_OUTER;
          req.prev_pos_x = DATA_W'(ball_x);
          req.prev_pos_y = DATA_W'(ball_y);
          ball_x = clip32(ball_x + (as_long(shadow_cfg.target_x) - ball_x) / 8 + random_step());
          ball_y = clip32(ball_y + (as_long(shadow_cfg.target_y) - ball_y) / 8 + random_step());
          req.pos_x = DATA_W'(ball_x);
          req.pos_y = DATA_W'(ball_y);
          // Broken history: previous sample does not match the last one sent
          if (kind >= 75) req.prev_pos_x = random_word();
        end else begin
          req.opcode = OP_INNER;
          off_x = ($urandom_range(3) == 0) ? 0 : random_step();
          off_y = ($urandom_range(3) == 0) ? 0 : random_step();
          req.tilt_x = DATA_W'(clip32(tilt_ref_x + off_x));
          req.tilt_y = DATA_W'(clip32(tilt_ref_y + off_y));
        end
      end
      send_request(req);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero gains after reset: every result must be zero whatever the inputs
  task automatic test_reset_defaults();
    send_request(make_outer(W_MIN, W_MAX, W_MAX, W_MIN));
    send_request(make_inner(W_MAX, W_MIN, W_MIN, W_MAX));
  endtask

  // Unity proportional gain shows the axis crossing; then I and D terms join in
  task automatic test_crossed_axes();
    cfg_t c;
    c          = '0;
    c.kp       = 32'sh0001_0000;
    c.tilt_kp  = 32'sh0001_0000;
    c.tilt_kd  = 32'sh0000_8000;
    c.target_x = 32'sh0000_0800;
    c.target_y = -32'sh0000_0400;
    apply_config(c);
    send_request(make_outer(-32'sh2000, 32'sh1000, -32'sh2000, 32'sh1000));
    c.ki_dt     = 32'sh0000_8000;
    c.kd_inv_dt = 32'sh0002_0000;
    apply_config(c);
    send_request(make_outer(32'sh300, -32'sh500, -32'sh100, 32'sh200));
    send_request(make_inner(32'sh0, 32'sh0, 32'sh1234, -32'sh4321));
  endtask

  // Error, difference and product saturation, then truncation toward zero
  task automatic test_saturation_paths();
    cfg_t c;
    c           = shadow_cfg;
    c.kp        = W_MAX;
    c.ki_dt     = W_MIN;
    c.kd_inv_dt = W_MAX;
    c.target_x  = W_MAX;
    c.target_y  = W_MIN;
    apply_config(c);
    send_request(make_outer(W_MIN, W_MAX, W_MAX, W_MIN));
    c.target_x = '0;
    c.target_y = '0;
    apply_config(c);
    send_request(make_outer(W_MIN, W_MAX, W_MAX, W_MIN));
    c.kp        = 32'sd1;
    c.ki_dt     = '0;
    c.kd_inv_dt = '0;
    apply_config(c);
    send_request(make_outer(32'sd3, -32'sd3, 32'sd3, -32'sd3));
    send_request(make_outer(-32'sd65537, 32'sd65537, 32'sd0, 32'sd0));
  endtask

  // Zero tilt error kills the rate term; negating the most negative rate;
  // torque sum saturating both ways
  task automatic test_inner_law();
    cfg_t c;
    c         = shadow_cfg;
    c.tilt_kp = W_MAX;
    c.tilt_kd = W_MAX;
    apply_config(c);
    send_request(make_inner(DATA_W'(tilt_ref_x), DATA_W'(tilt_ref_y), W_MIN, W_MAX));
    send_request(make_inner(W_MIN, W_MIN, W_MIN, W_MAX));
    send_request(make_inner(W_MAX, W_MAX, W_MIN, 32'sd0));
    c.tilt_kp = W_MIN;
    c.tilt_kd = -32'sh0001_0000;
    apply_config(c);
    send_request(make_inner(random_word(), random_word(), random_word(), random_word()));
    send_request(make_inner(DATA_W'(tilt_ref_x + 1), DATA_W'(tilt_ref_y - 1), W_MAX, W_MIN));
  endtask

  // A write past the last register must not disturb any gain or target
  task automatic test_unmapped_register();
    pid_req_t req;
    wait_idle();
    write_reg(REG_SPARE, $urandom);
    cfg_we <= 1'b0;
    req        = random_request();
    req.opcode = OP_OUTER;
    send_request(req);
    req        = random_request();
    req.opcode = OP_INNER;
    send_request(req);
  endtask

  // Four idling patterns, fresh gains per phase; one mid-phase drain
  task automatic test_random_traffic();
    int phase_idle[4]  = '{0, 47, 0, 17};
    int phase_stall[4] = '{0, 0, 47, 17};
    for (int p = 0; p < 4; p++) begin
      apply_config(random_config());
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 1) begin
        run_traffic(RANDOM_ITEMS / 8);
        wait_idle();
        run_traffic(RANDOM_ITEMS / 8);
      end else begin
        run_traffic(RANDOM_ITEMS / 4);
      end
    end
  endtask

  // Full-scale errors build the x error sum up and the y sum down far past
  // 32 bits, then the ball sits on the targets so both sums hold still
  task automatic test_error_sum_run();
    cfg_t     c;
    pid_req_t req;
    c           = random_config();
    c.kp        = '0;
    c.kd_inv_dt = '0;
    c.ki_dt     = 32'sd1;
    c.target_x  = W_MAX;
    c.target_y  = W_MIN;
    apply_config(c);
    idle_pct  = 0;
    stall_pct = 0;
    for (int n = 0; n < 128; n++) begin
      if (n % 32 == 31) begin
        req        = random_request();
        req.opcode = OP_INNER;
      end else if (n < 96) begin
        req = make_outer(W_MIN, W_MAX, random_word(), random_word());
      end else begin
        req = make_outer(W_MAX, W_MIN, random_word(), random_word());
      end
      send_request(req);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_crossed_axes();
    test_saturation_paths();
    test_inner_law();
    test_unmapped_register();
    test_random_traffic();
    test_error_sum_run();

    // Drain, then give the two-stage pipeline time to show any stray result
    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("covered %0d position updates and %0d pose requests, %0d results checked",
             outer_count, inner_count, results_checked);
    $display("%0d register writes including extreme gains and long one-sided error runs",
             reg_writes);
    if (mismatches == 0) begin
      $display("cascaded_two_axis_pid: match");
    end else begin
      $display("cascaded_two_axis_pid: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cpid_pkg.sv
hw/rtl/cpid_cfg.sv
hw/rtl/cpid_front.sv
hw/rtl/cpid_law.sv
hw/rtl/cascaded_two_axis_pid.sv
dv/cascaded_two_axis_pid_tb.sv
